// File: design/amdd_pkg.sv
package amdd_pkg;

    localparam int ROW_INDEX_BITS    = 3;
    localparam int COLUMN_INDEX_BITS = 3;
    localparam int SAMPLE_PORT_BITS  = 10;
    localparam int THRESHOLD_BITS    = 10;
    localparam int EVENT_VALUE_BITS  = 7;
    localparam int EVENT_SHIFT       = 3;
    localparam int ZERO_LIMIT        = 2;

    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = THRESHOLD_BITS'(8);

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_PRIME  = 1'b1;

    typedef logic [ROW_INDEX_BITS-1:0]    row_t;
    typedef logic [COLUMN_INDEX_BITS-1:0] column_t;
    typedef logic [THRESHOLD_BITS-1:0]    threshold_t;
    typedef logic [EVENT_VALUE_BITS-1:0]  event_value_t;

endpackage

// File: design/amdd_ram.sv
module amdd_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read returns the old word on a same-address write
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/analog_matrix_deadband_detector.sv
// An accepted word passes the compare stage, then its event word the m_ output register.
// Throughput: 1 word per cycle unless m_ stalls; one RAM read at accept and one write back
// from the compare stage, with a same-channel write forwarded into the following word.
// Reset (aresetn low, synchronous): pipeline and output emptied, all channels read as
// zero through per-channel valid bits, threshold_reg returns to 8.
module analog_matrix_deadband_detector #(
    parameter int ROWS        = 8,
    parameter int COLUMNS     = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [amdd_pkg::THRESHOLD_BITS-1:0]   cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_mode,
    input  logic [amdd_pkg::ROW_INDEX_BITS-1:0]   s_row_index,
    input  logic [amdd_pkg::COLUMN_INDEX_BITS-1:0] s_column_index,
    input  logic [amdd_pkg::SAMPLE_PORT_BITS-1:0] s_sample,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [amdd_pkg::ROW_INDEX_BITS-1:0]   m_event_row,
    output logic [amdd_pkg::COLUMN_INDEX_BITS-1:0] m_event_column,
    output logic [amdd_pkg::EVENT_VALUE_BITS-1:0] m_event_value
);

    localparam int ROW_SPAN    = 1 << amdd_pkg::ROW_INDEX_BITS;
    localparam int COLUMN_SPAN = 1 << amdd_pkg::COLUMN_INDEX_BITS;
    localparam int ROWS_USED   = (ROWS < ROW_SPAN) ? ROWS : ROW_SPAN;
    localparam int COLS_USED   = (COLUMNS < COLUMN_SPAN) ? COLUMNS : COLUMN_SPAN;
    localparam int DEPTH       = ROWS_USED * COLS_USED;
    localparam int ADDR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIDE_BITS   = (SAMPLE_BITS > amdd_pkg::SAMPLE_PORT_BITS) ?
                                 SAMPLE_BITS : amdd_pkg::SAMPLE_PORT_BITS;
    localparam int CMP_BITS    = (SAMPLE_BITS > amdd_pkg::THRESHOLD_BITS) ?
                                 SAMPLE_BITS : amdd_pkg::THRESHOLD_BITS;
    localparam int EV_HI       = amdd_pkg::EVENT_SHIFT + amdd_pkg::EVENT_VALUE_BITS - 1;

    // configuration
    amdd_pkg::threshold_t threshold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= amdd_pkg::THRESHOLD_RESET;
        end else if (cfg_valid) begin
            threshold_reg <= cfg_data;
        end
    end

    // accept side
    logic                   s_accept;
    logic [WIDE_BITS-1:0]   s_wide;
    logic [SAMPLE_BITS-1:0] s_fresh;
    logic                   s_inrange;
    logic [ADDR_BITS-1:0]   s_slot;

    assign s_wide  = WIDE_BITS'(s_sample);
    assign s_fresh = s_wide[SAMPLE_BITS-1:0];
    assign s_inrange =
        ({1'b0, s_row_index} < (amdd_pkg::ROW_INDEX_BITS + 1)'(ROWS_USED)) &&
        ({1'b0, s_column_index} < (amdd_pkg::COLUMN_INDEX_BITS + 1)'(COLS_USED));
    assign s_slot = s_inrange ?
        ADDR_BITS'(ADDR_BITS'(s_row_index) * ADDR_BITS'(COLS_USED) +
                   ADDR_BITS'(s_column_index)) : '0;

    // compare stage
    logic                          p1_valid_reg;
    logic                          p1_valid_next;
    logic                          p1_inrange_reg;
    logic                          p1_prime_reg;
    amdd_pkg::row_t                p1_row_reg;
    amdd_pkg::column_t             p1_col_reg;
    logic [SAMPLE_BITS-1:0]        p1_fresh_reg;
    logic [ADDR_BITS-1:0]          p1_slot_reg;
    logic                          p1_fwd_reg;
    logic [SAMPLE_BITS-1:0]        p1_fwd_data_reg;
    logic                          p1_entry_valid_reg;
    logic [DEPTH-1:0]              entry_valid_reg;

    logic                          p1_adv;
    logic [SAMPLE_BITS-1:0]        ram_rd_data;
    logic [SAMPLE_BITS-1:0]        held;
    logic [SAMPLE_BITS-1:0]        diff;
    logic                          big_change;
    logic                          settle_zero;
    logic                          p1_write;
    logic                          p1_event;
    logic                          wr_en;
    logic [SAMPLE_BITS-1:0]        wr_data;
    logic [WIDE_BITS-1:0]          p1_wide;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    amdd_pkg::row_t                m_row_reg;
    amdd_pkg::column_t             m_col_reg;
    amdd_pkg::event_value_t        m_value_reg;

    assign p1_adv   = !m_valid_reg || m_ready;
    assign s_ready  = !p1_valid_reg || p1_adv;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        if (p1_fwd_reg) begin
            held = p1_fwd_data_reg;
        end else if (p1_entry_valid_reg) begin
            held = ram_rd_data;
        end else begin
            held = '0;
        end
    end

    assign diff        = (p1_fresh_reg > held) ? p1_fresh_reg - held : held - p1_fresh_reg;
    assign big_change  = CMP_BITS'(diff) > CMP_BITS'(threshold_reg);
    assign settle_zero = (p1_fresh_reg != held) &&
                         (p1_fresh_reg < SAMPLE_BITS'(amdd_pkg::ZERO_LIMIT));
    assign p1_write    = p1_inrange_reg &&
                         ((p1_prime_reg == amdd_pkg::MODE_PRIME) || big_change || settle_zero);
    assign p1_event    = p1_inrange_reg && (p1_prime_reg == amdd_pkg::MODE_SAMPLE) &&
                         (big_change || settle_zero);
    assign wr_en       = p1_valid_reg && p1_adv && p1_write;
    assign wr_data     = ((p1_prime_reg == amdd_pkg::MODE_PRIME) || big_change) ?
                         p1_fresh_reg : '0;
    assign p1_wide     = WIDE_BITS'(p1_fresh_reg);

    amdd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (p1_slot_reg),
        .wr_data (wr_data),
        .rd_en   (s_accept),
        .rd_addr (s_slot),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (p1_adv) begin
            m_valid_next = p1_valid_reg && p1_event;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            entry_valid_reg <= '0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (wr_en) begin
                entry_valid_reg[p1_slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_inrange_reg     <= s_inrange;
            p1_prime_reg       <= s_mode;
            p1_row_reg         <= s_row_index;
            p1_col_reg         <= s_column_index;
            p1_fresh_reg       <= s_fresh;
            p1_slot_reg        <= s_slot;
            // forward the word being written back to the same channel
            p1_fwd_reg         <= wr_en && (p1_slot_reg == s_slot);
            p1_fwd_data_reg    <= wr_data;
            p1_entry_valid_reg <= entry_valid_reg[s_slot];
        end
        if (p1_adv && p1_valid_reg && p1_event) begin
            m_row_reg   <= p1_row_reg;
            m_col_reg   <= p1_col_reg;
            m_value_reg <= p1_wide[EV_HI:amdd_pkg::EVENT_SHIFT];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_row    = m_row_reg;
    assign m_event_column = m_col_reg;
    assign m_event_value  = m_value_reg;

endmodule

// File: design/amdd_checker.sv
module amdd_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic                                   s_mode,
    input logic [amdd_pkg::ROW_INDEX_BITS-1:0]    s_row_index,
    input logic [amdd_pkg::COLUMN_INDEX_BITS-1:0] s_column_index,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic [amdd_pkg::ROW_INDEX_BITS-1:0]    m_event_row,
    input logic [amdd_pkg::COLUMN_INDEX_BITS-1:0] m_event_column,
    input logic [amdd_pkg::EVENT_VALUE_BITS-1:0]  m_event_value
);

    logic m_stall;
    logic s_take;

    assign m_stall = m_valid && !m_ready;
    assign s_take  = s_valid && s_ready;

    // a stalled event word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_stall |=> m_valid && $stable(m_event_row) && $stable(m_event_column) &&
                    $stable(m_event_value))
        else $error("event word changed while stalled");

    // an open output never backs up the input side
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output can drain");

    // an event with no stall behind it comes from the matching sampling word that passed the compare stage
    a_event_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_stall) && !$past(m_stall, 2)) |->
            ($past(s_take, 2) && $past(s_mode, 2) == amdd_pkg::MODE_SAMPLE &&
             $past(s_row_index, 2) == m_event_row &&
             $past(s_column_index, 2) == m_event_column))
        else $error("event without matching sampling word");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind analog_matrix_deadband_detector amdd_checker u_amdd_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int ROWS        = 8;
    localparam int COLUMNS     = 8;
    localparam int SAMPLE_BITS = 10;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 125;

    typedef logic [amdd_pkg::SAMPLE_PORT_BITS-1:0] sample_t;
    typedef logic [SAMPLE_BITS-1:0]                level_t;

    typedef struct packed {
        amdd_pkg::row_t         row;
        amdd_pkg::column_t      column;
        amdd_pkg::event_value_t value;
    } level_event_t;

    typedef struct packed {
        logic                   mode;
        amdd_pkg::row_t         row;
        amdd_pkg::column_t      column;
        sample_t                sample;
        logic                   typed;
        logic                   fires;
        amdd_pkg::event_value_t value;
    } probe_t;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    amdd_pkg::threshold_t   cfg_data       = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic                   s_mode         = amdd_pkg::MODE_SAMPLE;
    amdd_pkg::row_t         s_row_index    = '0;
    amdd_pkg::column_t      s_column_index = '0;
    sample_t                s_sample       = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    amdd_pkg::row_t         m_event_row;
    amdd_pkg::column_t      m_event_column;
    amdd_pkg::event_value_t m_event_value;

    level_t                 channel_level [ROWS*COLUMNS];
    amdd_pkg::threshold_t   threshold_q;
    level_event_t           pending_events [$];
    int                     mismatches = 0;
    logic [8:0]             rx_tick = '0;

    // typed rows assume the reset threshold of 8 and all channels at zero
    probe_t probe_table [24] = '{
        '{amdd_pkg::MODE_SAMPLE, 3'd0, 3'd0, 10'd0,    1'b1, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd0, 3'd0, 10'd9,    1'b1, 1'b1, 7'd1},
        '{amdd_pkg::MODE_SAMPLE, 3'd0, 3'd0, 10'd17,   1'b1, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd0, 3'd0, 10'd1,    1'b1, 1'b1, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd0, 3'd0, 10'd1,    1'b1, 1'b1, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd0, 3'd0, 10'd0,    1'b1, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd7, 3'd7, 10'd1023, 1'b1, 1'b1, 7'd127},
        '{amdd_pkg::MODE_SAMPLE, 3'd7, 3'd7, 10'd0,    1'b1, 1'b1, 7'd0},
        '{amdd_pkg::MODE_PRIME,  3'd3, 3'd5, 10'd1023, 1'b1, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd3, 3'd5, 10'd1020, 1'b1, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd3, 3'd5, 10'd0,    1'b1, 1'b1, 7'd0},
        '{amdd_pkg::MODE_PRIME,  3'd3, 3'd5, 10'd512,  1'b1, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd3, 3'd5, 10'd520,  1'b1, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd3, 3'd5, 10'd521,  1'b1, 1'b1, 7'd65},
        '{amdd_pkg::MODE_SAMPLE, 3'd5, 3'd2, 10'd2,    1'b1, 1'b0, 7'd0},
        '{amdd_pkg::MODE_PRIME,  3'd5, 3'd2, 10'd1,    1'b1, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd5, 3'd2, 10'd1,    1'b1, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd5, 3'd2, 10'd0,    1'b1, 1'b1, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd2, 3'd6, 10'd682,  1'b0, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd6, 3'd1, 10'd341,  1'b0, 1'b0, 7'd0},
        '{amdd_pkg::MODE_PRIME,  3'd1, 3'd3, 10'd1023, 1'b0, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd1, 3'd3, 10'd1000, 1'b0, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd1, 3'd3, 10'd2,    1'b0, 1'b0, 7'd0},
        '{amdd_pkg::MODE_SAMPLE, 3'd4, 3'd0, 10'd1,    1'b1, 1'b1, 7'd0}
    };

    // negative entries draw a random threshold
    int threshold_plan [PHASES] = '{0, 1023, 1, -1, 2, 1022, -1, 8, 512, -1};

    analog_matrix_deadband_detector #(
        .ROWS        (ROWS),
        .COLUMNS     (COLUMNS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_row_index    (s_row_index),
        .s_column_index (s_column_index),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_row    (m_event_row),
        .m_event_column (m_event_column),
        .m_event_value  (m_event_value)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // update the channel levels for one accepted word; return 1 when it raises an event
    function automatic logic settle_channel(input logic mode, input amdd_pkg::row_t r,
                                            input amdd_pkg::column_t c,
                                            input sample_t raw, output level_event_t ev);
        int unsigned slot;
        level_t      fresh;
        level_t      held;
        level_t      delta;
        ev    = '0;
        fresh = level_t'(raw);
        if (r >= ROWS || c >= COLUMNS)
            return 1'b0;
        slot = r * COLUMNS + c;
        if (mode == amdd_pkg::MODE_PRIME) begin
            channel_level[slot] = fresh;
            return 1'b0;
        end
        held  = channel_level[slot];
        delta = (fresh > held) ? fresh - held : held - fresh;
        ev    = '{row: r, column: c,
                  value: amdd_pkg::event_value_t'(fresh >> amdd_pkg::EVENT_SHIFT)};
        if (int'(delta) > int'(threshold_q)) begin
            channel_level[slot] = fresh;
            return 1'b1;
        end
        // let the channel settle at zero inside the deadband
        if (fresh != held && int'(fresh) < amdd_pkg::ZERO_LIMIT) begin
            channel_level[slot] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_word(input logic mode, input amdd_pkg::row_t r,
                             input amdd_pkg::column_t c,
                             input sample_t smp, input logic typed, input logic fires,
                             input amdd_pkg::event_value_t value);
        level_event_t ev;
        logic         fired;
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_row_index    <= r;
        s_column_index <= c;
        s_sample       <= smp;
        do @(posedge aclk); while (!s_ready);
        fired = settle_channel(mode, r, c, smp, ev);
        if (typed) begin
            if (fires)
                pending_events.push_back('{row: r, column: c, value: value});
        end else if (fired) begin
            pending_events.push_back(ev);
        end
    endtask

    task automatic hold_off(input int unsigned cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // hold the sender until every event word is out and the pipeline has emptied
    task automatic drain_events();
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_threshold(input amdd_pkg::threshold_t level);
        cfg_data  <= level;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        threshold_q = level;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // receiver: full rate, coin flip, mostly stalled, then a periodic long stall
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 9'd1;
        case (rx_tick[8:7])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_tick[4:0] < 5'd20);
        endcase
    end

    always @(posedge aclk) begin : check_events
        level_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event word: row %0d column %0d value %0d",
                       m_event_row, m_event_column, m_event_value);
                mismatches++;
            end else begin
                want = pending_events.pop_front();
                if (m_event_row !== want.row) begin
                    $error("event_row: expected %0d, got %0d", want.row, m_event_row);
                    mismatches++;
                end
                if (m_event_column !== want.column) begin
                    $error("event_column: expected %0d, got %0d", want.column, m_event_column);
                    mismatches++;
                end
                if (m_event_value !== want.value) begin
                    $error("event_value: expected %0d, got %0d", want.value, m_event_value);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        amdd_pkg::row_t    r;
        amdd_pkg::column_t c;
        logic              mode;
        int                held_i;
        int                off;
        int                smp;
        int unsigned       kind;
        int unsigned       burst_left;
        logic              steady;
        foreach (channel_level[i])
            channel_level[i] = '0;
        threshold_q = amdd_pkg::THRESHOLD_RESET;
        r = '0;
        c = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words go back to back to hit same-channel forwarding
        foreach (probe_table[i])
            send_word(probe_table[i].mode, probe_table[i].row, probe_table[i].column,
                      probe_table[i].sample, probe_table[i].typed, probe_table[i].fires,
                      probe_table[i].value);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_events();
            if (threshold_plan[phase] < 0)
                write_threshold(amdd_pkg::threshold_t'($urandom_range(0, 1023)));
            else
                write_threshold(amdd_pkg::threshold_t'(threshold_plan[phase]));
            steady     = (phase % 3 == 2);
            burst_left = $urandom_range(1, 16);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                kind = $urandom_range(0, 99);
                if (kind < 20) begin
                    r = amdd_pkg::row_t'($urandom_range(0, 1));
                    c = amdd_pkg::column_t'($urandom_range(0, 1));
                end else if (kind >= 60) begin
                    r = amdd_pkg::row_t'($urandom_range(0, ROWS - 1));
                    c = amdd_pkg::column_t'($urandom_range(0, COLUMNS - 1));
                end
                // otherwise repeat the previous channel
                held_i = int'(channel_level[r * COLUMNS + c]);
                mode   = amdd_pkg::MODE_SAMPLE;
                kind   = $urandom_range(0, 99);
                if (kind < 30) begin
                    smp = $urandom_range(0, 1023);
                end else if (kind < 55) begin
                    off = int'(threshold_q) + int'($urandom_range(0, 3)) - 1;
                    smp = $urandom_range(0, 1) ? held_i + off : held_i - off;
                end else if (kind < 70) begin
                    smp = $urandom_range(0, 1);
                end else if (kind < 80) begin
                    smp = held_i;
                end else if (kind < 90) begin
                    smp = held_i + int'($urandom_range(0, 4)) - 2;
                end else begin
                    mode = amdd_pkg::MODE_PRIME;
                    smp  = $urandom_range(0, 1023);
                end
                if (smp < 0)
                    smp = 0;
                if (smp > 1023)
                    smp = 1023;
                send_word(mode, r, c, sample_t'(smp), 1'b0, 1'b0, '0);
                if (!steady) begin
                    burst_left = burst_left - 1;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 3) != 0)
                            hold_off($urandom_range(1, 6));
                        burst_left = $urandom_range(1, 16);
                    end
                end
            end
        end

        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
design/amdd_pkg.sv
design/amdd_ram.sv
design/analog_matrix_deadband_detector.sv
design/amdd_checker.sv
tb/sv/tb_top.sv
